// ===== rtl/dthf_pkg.sv =====
package dthf_pkg;

	localparam int DBL_W       = 64;
	localparam int D_MANT_BITS = 52;
	localparam int D_EXP_W     = 11;
	localparam int D_BIAS      = 1023;
	localparam int H_EXP_W     = 5;
	localparam int H_FRAC_W    = 10;
	localparam int H_BIAS      = 15;

	localparam logic [D_EXP_W-1:0] D_EXP_ALL1 = '1;

	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_OVF,
		CLS_NORM,
		CLS_SUB
	} cls_t;

endpackage

// ===== rtl/double_to_half_fields_unit.sv =====
// Double to half field converter.
// Channels: an input transaction is taken on a rising clock edge with start high
// and busy low. The block has no internal back-pressure, so busy is always low
// and one value can enter on every cycle.
// A result transaction is shown on half_sign, half_exponent and half_fraction
// for exactly one cycle, marked by done high.
// Throughput is one value per cycle, set by the three-stage
// pipeline: classification, subnormal shift and result register.
// Each result is a truncated conversion: no rounding is done.
// Overflow and infinity give exponent 31, while NaN and zero give positive zero.
// Reset clears all stage valid bits, so no done appears until new input.
// The receiver cannot stall, so every result is delivered on the cycle
// that it leaves the last stage.
module double_to_half_fields_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [dthf_pkg::DBL_W-1:0]      double_bits,
	output logic                            done,
	output logic                            half_sign,
	output logic [dthf_pkg::H_EXP_W-1:0]    half_exponent,
	output logic [dthf_pkg::H_FRAC_W-1:0]   half_fraction
);
	import dthf_pkg::*;

	logic                   neg_in;
	logic [D_EXP_W-1:0]     dexp_in;
	logic [D_MANT_BITS-1:0] mant_in;
	cls_t                   cls_c;
	logic                   sign_c;
	logic [D_EXP_W-1:0]     sh_c;

	logic                   v_s1, v_s2, v_s3;
	cls_t                   cls_s1;
	logic                   sign_s1, sign_s2, sign_s3;
	logic [D_EXP_W-1:0]     dexp_s1;
	logic [D_MANT_BITS-1:0] mant_s1;
	logic [D_EXP_W-1:0]     sh_s1;
	logic [H_FRAC_W-1:0]    frac_s2;
	logic [H_EXP_W-1:0]     hexp_s2;
	logic [H_EXP_W-1:0]     hexp_s3;
	logic [H_FRAC_W-1:0]    frac_s3;
	logic [H_FRAC_W:0]      full_top;
	logic [H_FRAC_W-1:0]    sub_frac;

	localparam logic [D_EXP_W-1:0] E_TOP  = D_EXP_W'(D_BIAS + H_BIAS);
	localparam logic [D_EXP_W-1:0] E_LOW  = D_EXP_W'(D_BIAS + 1 - H_BIAS);
	localparam logic [D_EXP_W-1:0] SH_BASE = D_EXP_W'(D_BIAS + D_MANT_BITS
		- (H_BIAS - 1 + H_FRAC_W) - (D_MANT_BITS - H_FRAC_W));
	localparam logic [D_MANT_BITS-H_FRAC_W-1:0] LOW_ZERO = '0;

	assign busy    = 1'b0;
	assign neg_in  = double_bits[DBL_W-1];
	assign dexp_in = double_bits[DBL_W-2 -: D_EXP_W];
	assign mant_in = double_bits[D_MANT_BITS-1:0];
	assign sh_c    = SH_BASE - dexp_in;

	always_comb begin
		cls_c  = CLS_ZERO;
		sign_c = 1'b0;
		if (dexp_in == D_EXP_ALL1) begin
			if (mant_in == '0) begin
				cls_c  = CLS_OVF;
				sign_c = neg_in;
			end
		end else if (dexp_in == '0) begin
			sign_c = (mant_in != '0) ? neg_in : 1'b0;
		end else begin
			sign_c = neg_in;
			if (dexp_in > E_TOP || (dexp_in == E_TOP &&
				mant_in[D_MANT_BITS-1 -: H_FRAC_W] == '1 &&
				mant_in[D_MANT_BITS-H_FRAC_W-1:0] != LOW_ZERO)) begin
				cls_c = CLS_OVF;
			end else if (dexp_in >= E_LOW) begin
				cls_c = CLS_NORM;
			end else begin
				cls_c = CLS_SUB;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		cls_s1  <= cls_c;
		sign_s1 <= sign_c;
		dexp_s1 <= dexp_in;
		mant_s1 <= mant_in;
		sh_s1   <= sh_c;
	end

	// The subnormal shift works on the top eleven significand bits only,
	// since the low bits never reach the ten-bit result.
	assign full_top = {1'b1, mant_s1[D_MANT_BITS-1 -: H_FRAC_W]};
	assign sub_frac = (sh_s1 > D_EXP_W'(H_FRAC_W)) ? '0
		: H_FRAC_W'(full_top >> sh_s1[3:0]);

	always_ff @(posedge clk) begin
		sign_s2 <= sign_s1;
		case (cls_s1)
			CLS_OVF: begin
				hexp_s2 <= '1;
				frac_s2 <= '0;
			end
			CLS_NORM: begin
				hexp_s2 <= H_EXP_W'(dexp_s1 - D_EXP_W'(D_BIAS - H_BIAS));
				frac_s2 <= mant_s1[D_MANT_BITS-1 -: H_FRAC_W];
			end
			CLS_SUB: begin
				hexp_s2 <= '0;
				frac_s2 <= sub_frac;
			end
			default: begin
				hexp_s2 <= '0;
				frac_s2 <= '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		sign_s3 <= sign_s2;
		hexp_s3 <= hexp_s2;
		frac_s3 <= frac_s2;
	end

	assign done          = v_s3;
	assign half_sign     = sign_s3;
	assign half_exponent = hexp_s3;
	assign half_fraction = frac_s3;

endmodule
